/* rtl/mexp_pkg.sv */
package mexp_pkg;

    localparam int W         = 31;
    localparam int EXP_BITS  = 63;
    localparam int CNT_W     = $clog2(W);
    localparam int LAST_STEP = W - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RED,
        S_CHECK,
        S_MUL,
        S_SQR_GO,
        S_SQR,
        S_DONE
    } t_state;

    // Operation run by the shared modular multiplier.
    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
        logic e_zero;
        logic e_lsb;
        logic last;
    } t_stat;

endpackage

/* rtl/mexp_datapath.sv */
module mexp_datapath
    import mexp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_req_type,
    input  logic [W-1:0]        i_base,
    input  logic [62:0]         i_exponent,
    input  logic [W-1:0]        i_modulus,
    output t_stat               o_stat,
    output logic [W-1:0]        o_result
);

    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_sq;
    logic [W-1:0]        r_m;
    logic [EXP_BITS-1:0] r_e;
    logic [W-1:0]        r_prod;
    logic [W-1:0]        r_sh;
    logic [CNT_W-1:0]    r_cnt;
    t_op                 r_op;
    logic [W-1:0]        r_out;

    logic [W:0]          m_ext;
    logic [W:0]          addend;
    logic [W:0]          t0;
    logic [W:0]          t1;
    logic [W:0]          t2;
    logic [W:0]          t3;
    logic [EXP_BITS-1:0] e_load;
    logic [W-1:0]        final_val;

    assign m_ext = {1'b0, r_m};

    always_comb begin
        case (r_op)
            OP_RED:  addend = (W+1)'(1);
            OP_MUL:  addend = {1'b0, r_acc};
            default: addend = {1'b0, r_sq};
        endcase
    end

    // One bit of an interleaved multiply: double, reduce, add, reduce.
    // The running value stays below the modulus, so each reduction is one subtract.
    always_comb begin
        t0 = {r_prod, 1'b0};
        t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
        t2 = t1 + (r_sh[W-1] ? addend : '0);
        t3 = (t2 >= m_ext) ? t2 - m_ext : t2;
    end

    always_comb begin
        if (i_req_type) begin
            e_load = (i_modulus <= W'(2)) ? '0 : EXP_BITS'(i_modulus - W'(2));
        end else begin
            e_load = i_exponent[EXP_BITS-1:0];
        end
    end

    // A zero modulus turns every reduction into zero.
    always_comb begin
        if (r_m == '0) begin
            final_val = (r_e == '0) ? W'(1) : '0;
        end else begin
            final_val = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else begin
            if (i_cmd.load) begin
                r_acc <= W'(1);
                r_sq  <= i_base;
                r_m   <= i_modulus;
                r_e   <= e_load;
            end
            if (i_cmd.start) begin
                r_op   <= i_cmd.op;
                r_prod <= '0;
                r_sh   <= r_sq;
                r_cnt  <= '0;
            end
            if (i_cmd.step) begin
                r_prod <= t3[W-1:0];
                r_sh   <= {r_sh[W-2:0], 1'b0};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(LAST_STEP)) begin
                    case (r_op)
                        OP_MUL: r_acc <= t3[W-1:0];
                        OP_SQR: begin
                            r_sq <= t3[W-1:0];
                            r_e  <= r_e >> 1;
                        end
                        default: r_sq <= t3[W-1:0];
                    endcase
                end
            end
            if (i_cmd.emit) begin
                r_out <= final_val;
            end
        end
    end

    assign o_stat.m_zero = (r_m == '0);
    assign o_stat.e_zero = (r_e == '0);
    assign o_stat.e_lsb  = r_e[0];
    assign o_stat.last   = (r_cnt == CNT_W'(LAST_STEP));
    assign o_result      = r_out;

endmodule

/* rtl/mexp_ctrl.sv */
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state   = r_state;
        cmd       = '0;
        cmd.op    = OP_RED;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (i_stat.m_zero) begin
                    n_state = S_DONE;
                end else begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_RED;
                    n_state   = S_RED;
                end
            end
            S_RED: begin
                cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.e_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.e_lsb) begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_MUL;
                    n_state   = S_MUL;
                end else begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_SQR;
                    n_state   = S_SQR;
                end
            end
            S_MUL: begin
                cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_SQR_GO;
                end
            end
            S_SQR_GO: begin
                cmd.start = 1'b1;
                cmd.op    = OP_SQR;
                n_state   = S_SQR;
            end
            S_SQR: begin
                cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                // Wait here only while the previous result is still held.
                if (!r_ovalid || !i_stall) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.emit) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

/* rtl/modular_exponentiation.sv */
// Modular exponentiation: result = base ** exponent mod modulus, using
// right-to-left binary square-and-multiply.
// Input channel: i_valid / o_stall with i_req_type, i_base, i_exponent and
// i_modulus. An item is taken when i_valid is high and o_stall is low.
// With i_req_type set, the exponent is modulus - 2 (inverse modulo a prime).
// Output channel: o_valid / i_stall with o_result, one result per item.
// Every modular product runs on one bit-serial multiplier, one multiplier
// bit per cycle. The base is reduced first, then each exponent bit up to
// the highest set one costs a square plus a multiply when the bit is set,
// each product begun by a setup state (S_START, S_CHECK or S_SQR_GO).
// A zero exponent still costs the base reduction and a zero modulus skips
// every product. One item is in work at a time; the next can be accepted
// in the cycle after the result is written.
// The result sits in an output register, so a new item is accepted while a
// finished result waits; a finished item waits only if that register is
// still held by a stalled result.
// Reset is synchronous and active low; it empties the output register and
// returns the controller to idle.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_req_type,
    input  logic [W-1:0]  i_base,
    input  logic [62:0]   i_exponent,
    input  logic [W-1:0]  i_modulus,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [W-1:0]  o_result
);

    t_cmd  cmd;
    t_stat stat;

    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mexp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req_type (i_req_type),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_modulus  (i_modulus),
        .o_stat     (stat),
        .o_result   (o_result)
    );

    // A new result never overwrites one that the receiver has not taken.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_valid || !i_stall))
        else $error("result emitted over a held result");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block idle right after accepting an item");

    // The multiplier is never started with a zero modulus.
    a_no_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> !stat.m_zero)
        else $error("modular product started with zero modulus");

    // Emitting a result and loading a new item never coincide.
    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.emit))
        else $error("load and emit in the same cycle");

endmodule

/* test/testbench.sv */
module testbench;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 1200;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic          o_stall;
    logic          i_req_type = 1'b0;
    logic [W-1:0]  i_base     = '0;
    logic [62:0]   i_exponent = '0;
    logic [W-1:0]  i_modulus  = '0;
    logic          o_valid;
    logic          i_stall    = 1'b0;
    logic [W-1:0]  o_result;

    logic [W-1:0]  pending_powers[$];
    int unsigned   n_sent     = 0;
    int unsigned   n_checked  = 0;
    int unsigned   n_errors   = 0;
    bit            jitter_on  = 1'b1;
    int unsigned   hold_len   = 0;

    modular_exponentiation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_modulus  (i_modulus),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Right-to-left square-and-multiply on 64-bit words. The base enters
    // unreduced, and a zero modulus turns every reduction into zero.
    function automatic logic [W-1:0] mod_power(logic req, logic [W-1:0] b,
                                               logic [62:0] e_in, logic [W-1:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] e;
        logic [63:0] mm;
        acc = 64'd1;
        sq  = {33'd0, b};
        mm  = {33'd0, m};
        if (req) begin
            e = (mm <= 64'd2) ? 64'd0 : mm - 64'd2;
        end else begin
            e = {1'b0, e_in};
        end
        for (int i = 0; i < EXP_BITS; i++) begin
            if (e == 64'd0) break;
            if (e[0]) begin
                acc = (mm == 64'd0) ? 64'd0 : (acc * sq) % mm;
            end
            sq = (mm == 64'd0) ? 64'd0 : (sq * sq) % mm;
            e  = e >> 1;
        end
        return acc[W-1:0];
    endfunction

    task automatic send_item(logic req, logic [W-1:0] b, logic [62:0] e,
                             logic [W-1:0] m);
        if (jitter_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_powers.insert(pending_powers.size(), mod_power(req, b, e, m));
        n_sent++;
    endtask

    // Most exponents are short to keep the run fast; some use all 63 bits.
    task automatic send_random_power(bit short_only);
        logic [63:0]  raw;
        logic [62:0]  e;
        logic [W-1:0] b;
        logic [W-1:0] m;
        logic         req;
        int unsigned  nbits;
        raw   = {$urandom, $urandom};
        nbits = (!short_only && $urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 16);
        e     = (nbits == 63) ? raw[62:0] : raw[62:0] & ((63'd1 << nbits) - 63'd1);
        case ($urandom_range(0, 5))
            0:       b = W'($urandom_range(0, 20));
            1:       b = '1;
            default: b = W'($urandom);
        endcase
        case ($urandom_range(0, 19))
            0:       m = '0;
            1, 2:    m = W'($urandom_range(1, 20));
            3:       m = '1;
            default: m = W'($urandom);
        endcase
        if (m == '0 && $urandom_range(0, 1) == 0) m = 31'd1;
        req = (!short_only && $urandom_range(0, 4) == 0);
        send_item(req, b, e, m);
    endtask

    task automatic test_power_edges();
        send_item(1'b0, 31'd0, 63'd0, 31'd1);
        send_item(1'b0, '1, '1, '1);
        send_item(1'b0, '1, 63'd1, '1);
        send_item(1'b0, '1, 63'd1, 31'd12345);
        send_item(1'b0, '1, 63'd2, 31'd2);
        send_item(1'b0, 31'd0, 63'd5, 31'd7);
        send_item(1'b0, 31'd987654, 63'd5, 31'd1);
        send_item(1'b0, 31'd987654, 63'd0, 31'd1);
        send_item(1'b0, '1, 63'd0, '1);
        send_item(1'b0, 31'd2, 63'd10, 31'd1000);
        send_item(1'b0, 31'd3, 63'd1 << 62, 31'd1000003);
        send_item(1'b0, 31'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 31'h2AAA_AAAB);
        // A zero modulus lies outside the normal range but the block defines it.
        send_item(1'b0, 31'd17, 63'd0, 31'd0);
        send_item(1'b0, 31'd17, 63'd3, 31'd0);
    endtask

    task automatic test_inverse();
        send_item(1'b1, 31'd5, 63'd9, 31'd0);
        send_item(1'b1, 31'd5, 63'd9, 31'd1);
        send_item(1'b1, '1, '1, 31'd2);
        send_item(1'b1, 31'd2, '0, 31'd3);
        send_item(1'b1, 31'd16807, '1, '1);
        send_item(1'b1, 31'd0, 63'd44, 31'd13);
        send_item(1'b1, '1, 63'd1, 31'd1000003);
    endtask

    task automatic test_random_powers();
        repeat (100) send_random_power(1'b0);
    endtask

    // The receiver holds off long enough that the output register and the
    // item in work both fill, so the block has to stall its input.
    task automatic test_back_pressure();
        hold_len = HOLD_CYCLES;
        repeat (6) send_item(1'b0, W'($urandom), 63'($urandom_range(0, 63)),
                             W'($urandom_range(1, 1000)));
    endtask

    task automatic test_steady_tail();
        jitter_on = 1'b0;
        repeat (15) send_random_power(1'b1);
        i_valid <= 1'b0;
    endtask

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_stall <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : result_check
        logic [W-1:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_powers.size() == 0) begin
                    $error("result: expected none, actual %0d", o_result);
                    n_errors++;
                end else begin
                    want = pending_powers.pop_front();
                    if (o_result !== want) begin
                        $error("result: expected %0d, actual %0d", want, o_result);
                        n_errors++;
                    end
                end
                n_checked++;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", pending_powers.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_edges();
        test_inverse();
        test_random_powers();
        test_back_pressure();
        test_steady_tail();
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Ran %0d items: edge powers, inverse requests, random powers and a long hold-off",
                 n_sent);
        $display("Checked %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && pending_powers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
